/* hw/rtl/spq_pkg.sv */
// shared types, sizes and codes for the sorted priority queue
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int STATUS_W    = 2;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // one stored entry
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] prio;
   } entry_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_cmd_type;

endpackage

/* hw/rtl/spq_cell.sv */
// one slot of the sorted chain: compare against the new item and shift
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_cmd_type cmd,
   input  logic                  occupied,
   input  logic                  left_le,
   input  spq_pkg::entry_type    new_entry,
   input  spq_pkg::entry_type    prev_entry,
   input  spq_pkg::entry_type    next_entry,
   output spq_pkg::entry_type    entry,
   output logic                  le
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // stored entry sorts at or ahead of the new item
   assign le = occupied &&
               ($signed(entry_ff.prio) <= $signed(new_entry.prio));

   // keep, take the new item, or shift right on insert; shift left on remove
   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (le) begin
            entry_in = entry_ff;
         end else if (left_le) begin
            entry_in = new_entry;
         end else begin
            entry_in = prev_entry;
         end
      end else if (cmd.remove) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* hw/rtl/sorted_priority_queue_core.sv */
// top level: sorted priority queue built as a chain of compare-and-shift cells
//
// Usage: drive req_opcode, req_item_value and req_item_priority with start
// high; the item is taken at the rising edge where start is high and busy is
// low. Opcode insert places the entry behind every stored entry of lower or
// equal priority (equal priorities leave in arrival order); opcode remove
// takes out the head, the entry of lowest signed priority.
// Every item gives one result, presented for exactly one cycle with rsp_valid
// high, in the cycle after the item is taken. It carries the status (done,
// refused because full, refused because empty), the removed entry (zero when
// nothing is removed) and the entry count after the operation.
// Throughput is one item per cycle: every cell compares its own priority with
// the new item and loads its new contents in the same cycle, so the cost of
// an operation does not depend on the fill level.
// Reset clears the entry count; cell contents are left as they are and are
// never read before they are written. busy is high while reset is held and
// in the cycle after it, then stays low. The receiver cannot stall, so
// results are never held back.
module sorted_priority_queue_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic signed [31:0]           req_item_value,
   input  logic signed [31:0]           req_item_priority,
   output logic                         rsp_valid,
   output logic [spq_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [31:0]           rsp_removed_value,
   output logic signed [31:0]           rsp_removed_priority,
   output logic [spq_pkg::COUNT_W-1:0]  rsp_entry_count
);

   localparam int DEPTH = spq_pkg::QUEUE_DEPTH;

   logic                         busy_ff;
   logic [spq_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                         rsp_valid_ff;
   logic [spq_pkg::STATUS_W-1:0] status_ff, status_in;
   spq_pkg::entry_type           removed_ff, removed_in;

   logic                  accept, full, empty, do_insert, do_remove;
   spq_pkg::cell_cmd_type cmd;
   spq_pkg::entry_type    new_entry;
   spq_pkg::entry_type    entries [DEPTH];
   logic [DEPTH-1:0]      le_vec;

   // command decode
   assign accept    = start && !busy_ff;
   assign full      = (count_ff == spq_pkg::COUNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_insert = accept && (req_opcode == spq_pkg::OP_INSERT) && !full;
   assign do_remove = accept && (req_opcode == spq_pkg::OP_REMOVE) && !empty;
   assign cmd.insert = do_insert;
   assign cmd.remove = do_remove;
   assign new_entry.value = req_item_value;
   assign new_entry.prio  = req_item_priority;

   // cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::entry_type prev_e, next_e;
      logic               left_le;
      if (i == 0) begin : g_head
         assign prev_e  = new_entry;
         assign left_le = 1'b1;
      end else begin : g_body
         assign prev_e  = entries[i-1];
         assign left_le = le_vec[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign next_e = entries[i];
      end else begin : g_inner
         assign next_e = entries[i+1];
      end
      spq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (spq_pkg::COUNT_W'(i) < count_ff),
         .left_le    (left_le),
         .new_entry  (new_entry),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .entry      (entries[i]),
         .le         (le_vec[i])
      );
   end

   // count and result
   always_comb begin
      count_in   = count_ff;
      status_in  = spq_pkg::ST_DONE;
      removed_in = '0;
      if (req_opcode == spq_pkg::OP_INSERT) begin
         if (full) begin
            status_in = spq_pkg::ST_FULL;
         end else if (do_insert) begin
            count_in = count_ff + spq_pkg::COUNT_W'(1);
         end
      end else begin
         if (empty) begin
            status_in = spq_pkg::ST_EMPTY;
         end else if (do_remove) begin
            removed_in = entries[0];
            count_in   = count_ff - spq_pkg::COUNT_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
      end
   end

   assign busy                 = busy_ff;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_removed_value    = removed_ff.value;
   assign rsp_removed_priority = removed_ff.prio;
   assign rsp_entry_count      = count_ff;

endmodule

/* tb/testbench.sv */
// self-checking testbench for the sorted priority queue core
`timescale 1ns / 100ps

module testbench;

   localparam int RESET_CYCLES   = 12;
   localparam int RANDOM_ITEMS   = 900;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;

   typedef logic signed [spq_pkg::DATA_W-1:0] word_type;

   // one result as the block reports it
   typedef struct packed {
      logic [spq_pkg::STATUS_W-1:0] status;
      word_type                     value;
      word_type                     prio;
      logic [spq_pkg::COUNT_W-1:0]  count;
   } queue_result_type;

   // one row of the directed table
   typedef struct {
      logic             op;
      word_type         value;
      word_type         prio;
      bit               typed;
      queue_result_type want;
   } drill_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic                         req_opcode = spq_pkg::OP_INSERT;
   word_type                     req_item_value = '0;
   word_type                     req_item_priority = '0;
   logic                         rsp_valid;
   logic [spq_pkg::STATUS_W-1:0] rsp_status;
   word_type                     rsp_removed_value;
   word_type                     rsp_removed_priority;
   logic [spq_pkg::COUNT_W-1:0]  rsp_entry_count;

   // predictor state: sorted store, head at slot 0
   word_type         model_value [spq_pkg::QUEUE_DEPTH];
   word_type         model_prio [spq_pkg::QUEUE_DEPTH];
   int               model_fill = 0;
   queue_result_type pending_results[$];
   drill_row_type    drill[$];
   int               errors = 0;
   bit               gap_free = 1'b0;

   sorted_priority_queue_core uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_opcode           (req_opcode),
      .req_item_value       (req_item_value),
      .req_item_priority    (req_item_priority),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_removed_value    (rsp_removed_value),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_entry_count      (rsp_entry_count)
   );

   // clock generation
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // apply one operation to the predicted store and return its result
   function automatic queue_result_type apply_queue_op(logic op, word_type value,
                                                       word_type prio);
      queue_result_type res;
      int               pos;
      int               i;
      res = '0;
      res.status = spq_pkg::ST_DONE;
      if (op == spq_pkg::OP_INSERT) begin
         if (model_fill >= spq_pkg::QUEUE_DEPTH) begin
            res.status = spq_pkg::ST_FULL;
         end else begin
            // new entry goes behind every entry of lower or equal priority
            pos = 0;
            while (pos < model_fill && model_prio[pos] <= prio) pos++;
            for (i = model_fill; i > pos; i--) begin
               model_value[i] = model_value[i-1];
               model_prio[i]  = model_prio[i-1];
            end
            model_value[pos] = value;
            model_prio[pos]  = prio;
            model_fill++;
         end
      end else begin
         if (model_fill == 0) begin
            res.status = spq_pkg::ST_EMPTY;
         end else begin
            res.value = model_value[0];
            res.prio  = model_prio[0];
            for (i = 1; i < model_fill; i++) begin
               model_value[i-1] = model_value[i];
               model_prio[i-1]  = model_prio[i];
            end
            model_fill--;
         end
      end
      res.count = model_fill[spq_pkg::COUNT_W-1:0];
      return res;
   endfunction

   // idle length before an item: mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   // random priority: dense ties most of the time, extremes now and then
   function automatic word_type pick_prio();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(0, 6) - 3;
      if (r < 80) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return -1;
         default: return 0;
      endcase
   endfunction

   task automatic add_row(logic op, word_type value, word_type prio, bit typed,
                          logic [spq_pkg::STATUS_W-1:0] status = spq_pkg::ST_DONE,
                          word_type rvalue = 0, word_type rprio = 0, int count = 0);
      drill_row_type row;
      row.op           = op;
      row.value        = value;
      row.prio         = prio;
      row.typed        = typed;
      row.want.status  = status;
      row.want.value   = rvalue;
      row.want.prio    = rprio;
      row.want.count   = count[spq_pkg::COUNT_W-1:0];
      drill.push_back(row);
   endtask

   // present one item, wait for it to be taken, then record what it should give
   task automatic send_item(logic op, word_type value, word_type prio,
                            bit typed = 1'b0, queue_result_type want = '0);
      int               gap;
      queue_result_type res;
      gap = gap_free ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_opcode        <= op;
      req_item_value    <= value;
      req_item_priority <= prio;
      do @(posedge clock); while (busy !== 1'b0);
      res = apply_queue_op(op, value, prio);
      pending_results.push_back(typed ? want : res);
   endtask

   // result checker
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("result arrived with no item outstanding");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_removed_value !== want.value) begin
               $error("removed_value: expected %0d, got %0d", want.value,
                      rsp_removed_value);
               errors++;
            end
            if (rsp_removed_priority !== want.prio) begin
               $error("removed_priority: expected %0d, got %0d", want.prio,
                      rsp_removed_priority);
               errors++;
            end
            if (rsp_entry_count !== want.count) begin
               $error("entry_count: expected %0d, got %0d", want.count,
                      rsp_entry_count);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no item and no result taken
   always @(posedge clock) begin
      int idle;
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         idle = 0;
      end else begin
         idle++;
         if (idle >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int k;
      int sent;
      int block_len;
      int insert_pct;
      for (k = 0; k < spq_pkg::QUEUE_DEPTH; k++) begin
         model_value[k] = '0;
         model_prio[k]  = '0;
      end

      // directed table: empty store, extremes, ties, ignored fields, full store
      add_row(spq_pkg::OP_REMOVE, -1, -1, 1'b1, spq_pkg::ST_EMPTY, 0, 0, 0);
      add_row(spq_pkg::OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1,
              spq_pkg::ST_DONE, 0, 0, 1);
      add_row(spq_pkg::OP_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b1,
              spq_pkg::ST_DONE, 0, 0, 2);
      add_row(spq_pkg::OP_INSERT, 1, 0, 1'b1, spq_pkg::ST_DONE, 0, 0, 3);
      add_row(spq_pkg::OP_INSERT, 2, 0, 1'b1, spq_pkg::ST_DONE, 0, 0, 4);
      add_row(spq_pkg::OP_REMOVE, 0, 0, 1'b1, spq_pkg::ST_DONE,
              32'h8000_0000, 32'h8000_0000, 3);
      add_row(spq_pkg::OP_REMOVE, 0, 0, 1'b1, spq_pkg::ST_DONE, 1, 0, 2);
      add_row(spq_pkg::OP_REMOVE, 32'hdead_beef, -5, 1'b1, spq_pkg::ST_DONE, 2, 0, 1);
      add_row(spq_pkg::OP_REMOVE, 0, 0, 1'b1, spq_pkg::ST_DONE,
              32'h7fff_ffff, 32'h7fff_ffff, 0);
      // fill with mixed and repeated priorities
      for (k = 0; k < spq_pkg::QUEUE_DEPTH; k++)
         add_row(spq_pkg::OP_INSERT, 100 + k, ((k * 7) % 5) - 2, 1'b0);
      add_row(spq_pkg::OP_INSERT, 32'h1234_5678, 0, 1'b1, spq_pkg::ST_FULL, 0, 0,
              spq_pkg::QUEUE_DEPTH);

      // reset
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (drill[j])
         send_item(drill[j].op, drill[j].value, drill[j].prio, drill[j].typed,
                   drill[j].want);

      // random part: blocks leaning toward insert, toward remove or balanced, so the store
      // swings between full and empty
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         block_len = $urandom_range(20, 60);
         case ($urandom_range(0, 2))
            0: insert_pct = 15;
            1: insert_pct = 50;
            default: insert_pct = 85;
         endcase
         gap_free = ($urandom_range(0, 3) == 0);
         for (k = 0; k < block_len && sent < RANDOM_ITEMS; k++) begin
            if ($urandom_range(0, 99) < insert_pct)
               send_item(spq_pkg::OP_INSERT, $urandom, pick_prio());
            else
               send_item(spq_pkg::OP_REMOVE, $urandom, $urandom);
            sent++;
         end
      end
      start <= 1'b0;

      // drain outstanding results
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
